/* src/fic_pkg.sv */
// ----------------------------------------------------------------------------
// fic_pkg
// Shared constants, types and helpers for the isclose compare pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fic_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;

  // element format codes
  localparam logic [1:0] FMT_B32  = 2'd0;
  localparam logic [1:0] FMT_B16  = 2'd1;
  localparam logic [1:0] FMT_BF16 = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FORMAT  = 2'd0;
  localparam logic [1:0] REG_REL_TOL = 2'd1;
  localparam logic [1:0] REG_ABS_TOL = 2'd2;
  localparam logic [1:0] REG_NAN_EQ  = 2'd3;

  // significand widths entering the rounder
  localparam int unsigned ADD_W = 57;
  localparam int unsigned MUL_W = 77;

  localparam int unsigned EXP_W   = 14;
  localparam int unsigned BIAS64  = 1023;
  localparam int unsigned EXP_INF = 2047;

  localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;

  typedef logic signed [EXP_W-1:0] exp_t;

  // result forced by an operand class (NaN or infinity)
  typedef struct packed {
    logic        special;
    logic [63:0] bits;
  } fspec_t;

  function automatic logic f64_is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'b0);
  endfunction

endpackage

/* src/fic_in_if.sv */
// ----------------------------------------------------------------------------
// fic_in_if
// Element pair channel: valid/ready with both raw elements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fic_in_if;
  import fic_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] elem_a;
  logic [ELEM_W-1:0] elem_b;

  modport source (output valid, elem_a, elem_b, input ready);
  modport sink   (input valid, elem_a, elem_b, output ready);
endinterface

/* src/fic_out_if.sv */
// ----------------------------------------------------------------------------
// fic_out_if
// Result channel: valid/ready with the closeness flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fic_out_if;
  logic valid;
  logic ready;
  logic is_close;

  modport source (output valid, is_close, input ready);
  modport sink   (input valid, is_close, output ready);
endinterface

/* src/float_isclose_compare_unit.sv */
// ----------------------------------------------------------------------------
// float_isclose_compare_unit
// Throughput: one pair per cycle while the result is taken; twelve pipeline
//   registers, each with a valid bit, and a stage holds only while the one
//   after it is full.
// Reset: rst clears all valid bits and the registers (format binary32,
//   tolerances +0, NaN equality off); no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module float_isclose_compare_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fic_pkg::APB_AW-1:0] paddr,
  input  logic [fic_pkg::APB_DW-1:0] pwdata,
  output logic [fic_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  fic_in_if.sink                     pair,
  fic_out_if.source                  result
);
  import fic_pkg::*;

  // Stage map (index of the register that holds the item):
  //   0      widen both elements to binary64
  //   1..2   diff = a - b front end, product rel_tolerance * |b| partials/sum
  //   3..5   round diff and product
  //   6..7   lim = abs_tolerance + product front end
  //   8..10  round lim
  //   11     compare, result register
  localparam int unsigned NST = 12;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  number_format;
  logic [63:0] rel_tolerance;
  logic [63:0] abs_tolerance;
  logic        nan_equal;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= FMT_B32;
      rel_tolerance <= '0;
      abs_tolerance <= '0;
      nan_equal     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FORMAT:  number_format <= pwdata[1:0];
        REG_REL_TOL: rel_tolerance <= pwdata;
        REG_ABS_TOL: abs_tolerance <= pwdata;
        REG_NAN_EQ:  nan_equal     <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORMAT:  prdata = {62'b0, number_format};
      REG_REL_TOL: prdata = rel_tolerance;
      REG_ABS_TOL: prdata = abs_tolerance;
      REG_NAN_EQ:  prdata = {63'b0, nan_equal};
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or the next one does,
  // so bubbles collapse and a pair can enter while the result waits.
  // --------------------------------------------------------------------------
  logic [NST-1:0] v;
  logic [NST-1:0] en;
  logic [NST-1:0] v_in;

  always_comb begin
    en[NST-1] = !v[NST-1] || result.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_in       = {v[NST-2:0], pair.valid};
  assign pair.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) v[k] <= v_in[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [63:0] a64;
  logic [63:0] b64;
  logic        a_nan;
  logic        b_nan;

  fic_widen u_widen (
    .clk           (clk),
    .en            (en[0]),
    .number_format (number_format),
    .elem_a        (pair.elem_a),
    .elem_b        (pair.elem_b),
    .a64           (a64),
    .b64           (b64),
    .a_nan         (a_nan),
    .b_nan         (b_nan)
  );

  // a - b: flip the sign of b and add
  logic [ADD_W-1:0] df_m;
  exp_t             df_e;
  logic             df_s;
  fspec_t           df_spec;
  logic [63:0]      diff_bits;

  fic_add u_diff_add (
    .clk      (clk),
    .en       (en[2:1]),
    .x        (a64),
    .y        ({~b64[63], b64[62:0]}),
    .sum_m    (df_m),
    .sum_e    (df_e),
    .sum_s    (df_s),
    .sum_spec (df_spec)
  );

  fic_round #(.W(ADD_W)) u_diff_round (
    .clk      (clk),
    .en       (en[5:3]),
    .in_m     (df_m),
    .in_e     (df_e),
    .in_s     (df_s),
    .in_spec  (df_spec),
    .out_bits (diff_bits)
  );

  // rel_tolerance * |b|
  logic [MUL_W-1:0] pr_m;
  exp_t             pr_e;
  logic             pr_s;
  fspec_t           pr_spec;
  logic [63:0]      prod_bits;

  fic_mul u_mul (
    .clk           (clk),
    .en            (en[2:1]),
    .rel_tolerance (rel_tolerance),
    .b64           (b64),
    .prod_m        (pr_m),
    .prod_e        (pr_e),
    .prod_s        (pr_s),
    .prod_spec     (pr_spec)
  );

  fic_round #(.W(MUL_W)) u_prod_round (
    .clk      (clk),
    .en       (en[5:3]),
    .in_m     (pr_m),
    .in_e     (pr_e),
    .in_s     (pr_s),
    .in_spec  (pr_spec),
    .out_bits (prod_bits)
  );

  // abs_tolerance + product
  logic [ADD_W-1:0] lm_m;
  exp_t             lm_e;
  logic             lm_s;
  fspec_t           lm_spec;
  logic [63:0]      lim_bits;

  fic_add u_lim_add (
    .clk      (clk),
    .en       (en[7:6]),
    .x        (abs_tolerance),
    .y        (prod_bits),
    .sum_m    (lm_m),
    .sum_e    (lm_e),
    .sum_s    (lm_s),
    .sum_spec (lm_spec)
  );

  fic_round #(.W(ADD_W)) u_lim_round (
    .clk      (clk),
    .en       (en[10:8]),
    .in_m     (lm_m),
    .in_e     (lm_e),
    .in_s     (lm_s),
    .in_spec  (lm_spec),
    .out_bits (lim_bits)
  );

  // Carry the NaN flags and the rounded diff alongside the stages they skip.
  logic [1:0]  nan_d  [1:10];
  logic [63:0] diff_d [6:10];

  always_ff @(posedge clk) begin
    if (en[1]) nan_d[1] <= {a_nan, b_nan};
    for (int k = 2; k <= 10; k++) begin
      if (en[k]) nan_d[k] <= nan_d[k-1];
    end
    if (en[6]) diff_d[6] <= diff_bits;
    for (int k = 7; k <= 10; k++) begin
      if (en[k]) diff_d[k] <= diff_d[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Compare |diff| <= lim. A NaN on one side gives false, NaNs on both give
  // nan_equal; a negative lim admits only a zero diff against a negative zero.
  // --------------------------------------------------------------------------
  logic [62:0] d_mag;
  logic        le;
  logic        cmp;
  logic        an;
  logic        bn;
  logic        close_next;
  logic        is_close;

  always_comb begin
    d_mag = diff_d[10][62:0];
    an    = nan_d[10][1];
    bn    = nan_d[10][0];
    if (!lim_bits[63]) begin
      le = d_mag <= lim_bits[62:0];
    end else begin
      le = (lim_bits[62:0] == 63'b0) && (d_mag == 63'b0);
    end
    cmp        = !f64_is_nan(diff_d[10]) && !f64_is_nan(lim_bits) && le;
    close_next = (an || bn) ? (nan_equal && an && bn) : cmp;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) is_close <= close_next;
  end

  assign result.valid    = v[NST-1];
  assign result.is_close = is_close;

`ifndef SYNTHESIS
  // Input stalls only when every stage holds an item and the result waits.
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !pair.ready |-> (&v) && !result.ready)
    else $error("input stalled with a free pipeline stage");

  // An accepted transfer always lands in the first stage.
  a_enter : assert property (@(posedge clk) disable iff (rst)
    pair.valid && pair.ready |=> v[0])
    else $error("accepted transfer lost at pipeline entry");
`endif

endmodule

/* src/fic_widen.sv */
// ----------------------------------------------------------------------------
// fic_widen
// Exact widening of both raw elements to binary64, one register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fic_widen (
  input  logic                      clk,
  input  logic                      en,
  input  logic [1:0]                number_format,
  input  logic [fic_pkg::ELEM_W-1:0] elem_a,
  input  logic [fic_pkg::ELEM_W-1:0] elem_b,
  output logic [63:0]               a64,
  output logic [63:0]               b64,
  output logic                      a_nan,
  output logic                      b_nan
);
  import fic_pkg::*;

  function automatic logic [63:0] widen(input logic [ELEM_W-1:0] raw, input logic [1:0] fmt);
    logic        s;
    logic [7:0]  e;
    logic [7:0]  emax;
    logic [22:0] m;
    logic [22:0] mn;
    logic [10:0] off;
    logic [4:0]  k;
    logic        found;
    unique case (fmt)
      FMT_B16: begin
        s    = raw[HALF_W-1];
        e    = {3'b0, raw[14:10]};
        m    = {raw[9:0], 13'b0};
        emax = 8'h1F;
        off  = 11'd1008;
      end
      FMT_BF16: begin
        s    = raw[HALF_W-1];
        e    = raw[14:7];
        m    = {raw[6:0], 16'b0};
        emax = 8'hFF;
        off  = 11'd896;
      end
      default: begin
        s    = raw[31];
        e    = raw[30:23];
        m    = raw[22:0];
        emax = 8'hFF;
        off  = 11'd896;
      end
    endcase
    // shift count that brings the leading one of a subnormal to the hidden place
    k     = 5'd0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found && m[i]) begin
        k     = 5'(23 - i);
        found = 1'b1;
      end
    end
    mn = m << k;
    if (e == emax) begin
      return {s, 11'h7FF, m, 29'b0};
    end else if (e == 8'd0 && m == 23'd0) begin
      return {s, 63'b0};
    end else if (e == 8'd0) begin
      return {s, off + 11'd1 - {6'b0, k}, mn, 29'b0};
    end else begin
      return {s, off + {3'b0, e}, m, 29'b0};
    end
  endfunction

  logic [63:0] wa;
  logic [63:0] wb;

  assign wa = widen(elem_a, number_format);
  assign wb = widen(elem_b, number_format);

  always_ff @(posedge clk) begin
    if (en) begin
      a64   <= wa;
      b64   <= wb;
      a_nan <= f64_is_nan(wa);
      b_nan <= f64_is_nan(wb);
    end
  end

endmodule

/* src/fic_mul.sv */
// ----------------------------------------------------------------------------
// fic_mul
// Exact product rel_tolerance * |b| in two stages: split partials, then sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fic_mul (
  input  logic                      clk,
  input  logic [1:0]                en,
  input  logic [63:0]               rel_tolerance,
  input  logic [63:0]               b64,
  output logic [fic_pkg::MUL_W-1:0] prod_m,
  output fic_pkg::exp_t             prod_e,
  output logic                      prod_s,
  output fic_pkg::fspec_t           prod_spec
);
  import fic_pkg::*;

  logic [10:0] er_f;
  logic [10:0] er_u;
  logic [10:0] eb_f;
  logic [52:0] mr;
  logic [23:0] mb;
  logic        r_nan;
  logic        r_inf;
  logic        r_zero;
  logic        b_inf;
  logic        b_zero;
  fspec_t      spec;
  exp_t        e_sum;

  always_comb begin
    er_f   = rel_tolerance[62:52];
    er_u   = (er_f == 11'd0) ? 11'd1 : er_f;
    eb_f   = b64[62:52];
    mr     = {er_f != 11'd0, rel_tolerance[51:0]};
    // widened elements carry at most 24 significant bits
    mb     = {eb_f != 11'd0, b64[51:29]};
    r_nan  = f64_is_nan(rel_tolerance);
    r_inf  = (er_f == 11'h7FF) && (rel_tolerance[51:0] == 52'b0);
    r_zero = rel_tolerance[62:0] == 63'b0;
    b_inf  = eb_f == 11'h7FF;
    b_zero = b64[62:0] == 63'b0;
    spec.special = r_nan | r_inf | b_inf;
    spec.bits    = (r_nan | (r_inf & b_zero) | (b_inf & r_zero)) ? QNAN64
                 : {rel_tolerance[63], 11'h7FF, 52'b0};
    e_sum = exp_t'({3'b0, er_u}) + exp_t'({3'b0, eb_f}) - exp_t'(2121);
  end

  logic [50:0] pp_hi;
  logic [49:0] pp_lo;
  exp_t        e1;
  logic        s1;
  fspec_t      spec1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_hi <= {24'b0, mr[52:26]} * {27'b0, mb};
      pp_lo <= {24'b0, mr[25:0]} * {26'b0, mb};
      e1    <= e_sum;
      s1    <= rel_tolerance[63];
      spec1 <= spec;
    end
    if (en[1]) begin
      prod_m    <= {pp_hi, 26'b0} + {27'b0, pp_lo};
      prod_e    <= e1;
      prod_s    <= s1;
      prod_spec <= spec1;
    end
  end

endmodule

/* src/fic_add.sv */
// ----------------------------------------------------------------------------
// fic_add
// binary64 add front end: swap and align with sticky, then add or subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fic_add (
  input  logic                      clk,
  input  logic [1:0]                en,
  input  logic [63:0]               x,
  input  logic [63:0]               y,
  output logic [fic_pkg::ADD_W-1:0] sum_m,
  output fic_pkg::exp_t             sum_e,
  output logic                      sum_s,
  output fic_pkg::fspec_t           sum_spec
);
  import fic_pkg::*;

  localparam int unsigned ALN_W = ADD_W - 1;

  logic             x_big;
  logic [63:0]      big;
  logic [63:0]      lit;
  logic [10:0]      e_big;
  logic [10:0]      e_lit;
  logic [10:0]      d;
  logic [ALN_W-1:0] m_big;
  logic [ALN_W-1:0] m_lit;
  logic [ALN_W-1:0] sh;
  logic [ALN_W-1:0] al;
  logic             lost;
  logic             xn;
  logic             yn;
  logic             xi;
  logic             yi;
  fspec_t           spec;

  always_comb begin
    x_big = x[62:0] >= y[62:0];
    big   = x_big ? x : y;
    lit   = x_big ? y : x;
    e_big = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    e_lit = (lit[62:52] == 11'd0) ? 11'd1 : lit[62:52];
    m_big = {big[62:52] != 11'd0, big[51:0], 3'b0};
    m_lit = {lit[62:52] != 11'd0, lit[51:0], 3'b0};
    d     = e_big - e_lit;
    sh    = m_lit >> d[5:0];
    lost  = |(m_lit & ~({ALN_W{1'b1}} << d[5:0]));
    if (d >= 11'(ALN_W)) begin
      al = {{(ALN_W-1){1'b0}}, |m_lit};
    end else begin
      al = {sh[ALN_W-1:1], sh[0] | lost};
    end
    xn = f64_is_nan(x);
    yn = f64_is_nan(y);
    xi = (x[62:52] == 11'h7FF) && (x[51:0] == 52'b0);
    yi = (y[62:52] == 11'h7FF) && (y[51:0] == 52'b0);
    spec.special = xn | yn | xi | yi;
    spec.bits    = (xn | yn | (xi & yi & (x[63] != y[63]))) ? QNAN64 : (xi ? x : y);
  end

  logic             s1;
  logic             sub1;
  logic [ALN_W-1:0] mb1;
  logic [ALN_W-1:0] al1;
  logic [10:0]      e1;
  fspec_t           spec1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1    <= big[63];
      sub1  <= big[63] ^ lit[63];
      mb1   <= m_big;
      al1   <= al;
      e1    <= e_big;
      spec1 <= spec;
    end
    if (en[1]) begin
      sum_m    <= sub1 ? ({1'b0, mb1} - {1'b0, al1}) : ({1'b0, mb1} + {1'b0, al1});
      sum_e    <= exp_t'({3'b0, e1}) - exp_t'(1078);
      sum_s    <= s1;
      sum_spec <= spec1;
    end
  end

endmodule

/* src/fic_round.sv */
// ----------------------------------------------------------------------------
// fic_round
// Normalize and round m * 2^e to binary64 (nearest even) over three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fic_round #(
  parameter int unsigned W = fic_pkg::ADD_W
) (
  input  logic            clk,
  input  logic [2:0]      en,
  input  logic [W-1:0]    in_m,
  input  fic_pkg::exp_t   in_e,
  input  logic            in_s,
  input  fic_pkg::fspec_t in_spec,
  output logic [63:0]     out_bits
);
  import fic_pkg::*;

  localparam int unsigned SH_W = $clog2(W + 2);
  localparam int unsigned WIDE = 2 * W;

  // leading zero count
  logic [SH_W-1:0] lz;

  always_comb begin
    lz = '0;
    for (int i = 0; i < W; i++) begin
      if (in_m[i]) lz = SH_W'(W - 1 - i);
    end
  end

  logic [W-1:0]    m1;
  exp_t            e1;
  logic            s1;
  logic            zero1;
  logic [SH_W-1:0] lz1;
  fspec_t          spec1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1    <= in_m;
      e1    <= in_e;
      s1    <= in_s;
      zero1 <= in_m == '0;
      lz1   <= lz;
      spec1 <= in_spec;
    end
  end

  // biased exponent and subnormal right shift
  exp_t            be;
  exp_t            neg;
  logic [SH_W-1:0] rs;

  always_comb begin
    be  = e1 + exp_t'(W - 1) - exp_t'(lz1) + exp_t'(BIAS64);
    neg = exp_t'(1) - be;
    priority if (be >= exp_t'(1)) begin
      rs = '0;
    end else if (neg > exp_t'(W + 1)) begin
      rs = SH_W'(W + 1);
    end else begin
      rs = neg[SH_W-1:0];
    end
  end

  logic [W-1:0]    m2;
  logic [10:0]     be2;
  logic [SH_W-1:0] rs2;
  logic            ovf2;
  logic            zero2;
  logic            s2;
  fspec_t          spec2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m2    <= m1 << lz1;
      be2   <= (be >= exp_t'(1)) ? be[10:0] : 11'd0;
      rs2   <= rs;
      ovf2  <= be >= exp_t'(EXP_INF);
      zero2 <= zero1;
      s2    <= s1;
      spec2 <= spec1;
    end
  end

  // round to nearest even; a carry out of the fraction bumps the exponent
  logic [WIDE-1:0] wide;
  logic [52:0]     kept;
  logic            guard;
  logic            stick;
  logic            inc;
  logic [62:0]     rounded;

  always_comb begin
    wide    = {m2, {W{1'b0}}} >> rs2;
    kept    = wide[WIDE-1 -: 53];
    guard   = wide[WIDE-54];
    stick   = |wide[WIDE-55:0];
    inc     = guard & (stick | kept[0]);
    rounded = {be2, kept[51:0]} + 63'(inc);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      priority if (spec2.special) begin
        out_bits <= spec2.bits;
      end else if (zero2) begin
        out_bits <= {s2, 63'b0};
      end else if (ovf2) begin
        out_bits <= {s2, 11'h7FF, 52'b0};
      end else begin
        out_bits <= {s2, rounded};
      end
    end
  end

endmodule
